// ===== sv/stb_pkg.sv =====
// Shared constants, codes and types for the software timer bank.
package stb_pkg;

   localparam int TIMER_COUNT = 16;
   localparam int ADDR_W      = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int MASK_W      = 16;
   localparam int COUNT_W     = 16;
   localparam int INDEX_W     = 4;

   localparam logic [7:0] PRESCALE_RESET = 8'd50;

   localparam logic [1:0] MODE_TICK  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_READ  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   localparam logic [1:0] KIND_PERIODIC = 2'd1;
   localparam logic [1:0] KIND_HOLD     = 2'd2;

   typedef struct packed {
      logic               run;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] target;
      logic [1:0]         kind;
      logic               trig;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_SWEEP,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic issue_idx;
      logic issue_sweep;
   } cmd_type;

   typedef struct packed {
      logic step_due;
      logic sweep_last;
   } stat_type;

endpackage

// ===== sv/software_timer_bank.sv =====
// Top level of the software timer bank: controller and datapath.
//
// Usage: raise start with an item on the req_ ports; it is taken on a rising
// edge where start is high and busy is low. req_mode selects a raw tick, a
// timer setup write, a timer read or a trigger clear. Every item gives exactly
// one result beat on the rsp_ ports, marked by rsp_valid for one cycle; the
// receiver must take it then, as results cannot be held off.
// Path of each item after the accepting edge, up to its result beat:
//   - raw tick that does not run a step: straight to the result beat;
//   - setup write, read, trigger clear: fetch, write back, result;
//   - raw tick that runs a step: the step walks the timer memory one entry
//     per cycle through its single read port, then write back and result.
// A new item may be taken in the cycle after the result beat.
// The user writes the prescale limit (csr_write_en, csr_write_data) only while
// idle; the block does not enforce it. Reset (synchronous, active high) clears
// all timers, the prescaler and blink dividers; the limit returns to fifty.
module software_timer_bank import stb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [INDEX_W-1:0] req_timer_index,
   input  logic [COUNT_W-1:0] req_set_count,
   input  logic [1:0]         req_timer_kind,
   input  logic               req_enable_in,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data,
   output logic               rsp_valid,
   output logic               rsp_stepped,
   output logic               rsp_blink_1,
   output logic               rsp_blink_2,
   output logic               rsp_blink_3,
   output logic               rsp_blink_5,
   output logic [MASK_W-1:0]  rsp_fired_mask,
   output logic [COUNT_W-1:0] rsp_count_value,
   output logic               rsp_enabled_out,
   output logic               rsp_triggered_out,
   output logic [1:0]         rsp_kind_out
);

   // command and status between the sequencer and the datapath
   cmd_type  cmd;
   stat_type stat;

   // sequence each item: accept, memory fetch or sweep and drain where needed, result beat
   stb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // hold timer state, prescaler, blinks and the result registers
   stb_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_mode          (req_mode),
      .req_timer_index   (req_timer_index),
      .req_set_count     (req_set_count),
      .req_timer_kind    (req_timer_kind),
      .req_enable_in     (req_enable_in),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_stepped       (rsp_stepped),
      .rsp_blink_1       (rsp_blink_1),
      .rsp_blink_2       (rsp_blink_2),
      .rsp_blink_3       (rsp_blink_3),
      .rsp_blink_5       (rsp_blink_5),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_count_value   (rsp_count_value),
      .rsp_enabled_out   (rsp_enabled_out),
      .rsp_triggered_out (rsp_triggered_out),
      .rsp_kind_out      (rsp_kind_out)
   );

endmodule

// ===== sv/stb_ctrl.sv =====
// Controller state machine for the software timer bank.
module stb_ctrl import stb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_mode,
   input  stat_type   stat,
   output cmd_type    cmd,
   output logic       busy,
   output logic       rsp_valid
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode == MODE_TICK) begin
                  state_in = stat.step_due ? ST_SWEEP : ST_RESP;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_DRAIN;
         end
         ST_SWEEP: begin
            if (stat.sweep_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.accept = start;
         end
         ST_FETCH: begin
            cmd.issue_idx = 1'b1;
         end
         ST_SWEEP: begin
            cmd.issue_sweep = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== sv/stb_datapath.sv =====
// Datapath of the software timer bank: timer memory, prescaler, blinks, result.
module stb_datapath import stb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_mode,
   input  logic [INDEX_W-1:0] req_timer_index,
   input  logic [COUNT_W-1:0] req_set_count,
   input  logic [1:0]         req_timer_kind,
   input  logic               req_enable_in,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic               rsp_stepped,
   output logic               rsp_blink_1,
   output logic               rsp_blink_2,
   output logic               rsp_blink_3,
   output logic               rsp_blink_5,
   output logic [MASK_W-1:0]  rsp_fired_mask,
   output logic [COUNT_W-1:0] rsp_count_value,
   output logic               rsp_enabled_out,
   output logic               rsp_triggered_out,
   output logic [1:0]         rsp_kind_out
);

   entry_type timer_mem [TIMER_COUNT];
   logic [TIMER_COUNT-1:0] vld_ff;
   entry_type              rd_data_ff;
   logic                   rd_vld_ff;
   logic                   rd_pend_ff;
   logic [ADDR_W-1:0]      rd_addr_ff;
   logic [ADDR_W-1:0]      ptr_ff, ptr_in;

   logic [1:0]         op_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [COUNT_W-1:0] set_ff;
   logic [1:0]         kind_ff;
   logic               en_ff;

   logic [7:0] limit_ff;
   logic [7:0] pc_ff, pc_in;
   logic [1:0] d2_ff, d2_in;
   logic [1:0] d3_ff, d3_in;
   logic [2:0] d5_ff, d5_in;
   logic [3:0] blink_ff, blink_in;

   logic               stepped_ff;
   logic [MASK_W-1:0]  fired_ff, fired_in;
   logic [COUNT_W-1:0] cnt_ff;
   logic               enr_ff;
   logic               trg_ff;
   logic [1:0]         knd_ff;

   logic [7:0]        pc_inc;
   logic              step_go;
   logic              rd_issue;
   logic [ADDR_W-1:0] rd_addr;
   logic              idx_ok;
   entry_type         cur;
   entry_type         stepped_ent;
   logic              fire;
   logic              wr_en;
   entry_type         wr_data;
   logic [COUNT_W-1:0] cnt_up;

   assign pc_inc          = pc_ff + 8'd1;
   assign stat.step_due   = (pc_inc >= limit_ff);
   assign stat.sweep_last = (ptr_ff == ADDR_W'(TIMER_COUNT - 1));
   assign step_go         = cmd.accept && (req_mode == MODE_TICK) && stat.step_due;
   assign rd_issue        = cmd.issue_idx || cmd.issue_sweep;
   assign rd_addr         = cmd.issue_sweep ? ptr_ff : ADDR_W'(idx_ff);
   assign idx_ok          = (int'(idx_ff) < TIMER_COUNT);
   assign cur             = rd_vld_ff ? rd_data_ff : '0;

   // one timer step on the entry just read
   always_comb begin
      stepped_ent = cur;
      fire        = 1'b0;
      cnt_up      = (cur.count < cur.target) ? cur.count + 16'd1 : cur.count;
      if (cur.run) begin
         stepped_ent.count = cnt_up;
         if (cnt_up >= cur.target) begin
            fire = 1'b1;
            stepped_ent.trig = 1'b1;
            if (cur.kind <= KIND_PERIODIC) begin
               stepped_ent.count = '0;
               stepped_ent.run   = cur.kind[0];
            end else begin
               stepped_ent.run = 1'b0;
            end
         end
      end else if (cur.kind != KIND_HOLD) begin
         stepped_ent.count = '0;
      end
   end

   always_comb begin
      wr_data = cur;
      wr_en   = 1'b0;
      case (op_ff)
         MODE_TICK: begin
            wr_en   = rd_pend_ff;
            wr_data = stepped_ent;
         end
         MODE_WRITE: begin
            wr_en          = rd_pend_ff && idx_ok;
            wr_data.target = set_ff;
            wr_data.kind   = kind_ff;
            wr_data.run    = en_ff;
         end
         MODE_CLEAR: begin
            wr_en        = rd_pend_ff && idx_ok;
            wr_data.trig = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      fired_in = fired_ff;
      if (cmd.accept) begin
         fired_in = '0;
      end else if (rd_pend_ff && (op_ff == MODE_TICK) && fire) begin
         for (int j = 0; j < MASK_W; j++) begin
            if (int'(rd_addr_ff) == j) begin
               fired_in[j] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.accept) begin
         ptr_in = '0;
      end else if (cmd.issue_sweep && !stat.sweep_last) begin
         ptr_in = ptr_ff + ADDR_W'(1);
      end
   end

   // prescaler and blink dividers
   always_comb begin
      pc_in    = pc_ff;
      d2_in    = d2_ff;
      d3_in    = d3_ff;
      d5_in    = d5_ff;
      blink_in = blink_ff;
      if (cmd.accept && (req_mode == MODE_TICK)) begin
         pc_in = step_go ? 8'd0 : pc_inc;
      end
      if (step_go) begin
         blink_in[0] = ~blink_ff[0];
         d2_in = d2_ff + 2'd1;
         d3_in = d3_ff + 2'd1;
         d5_in = d5_ff + 3'd1;
         if (d2_in >= 2'd2) begin
            blink_in[1] = ~blink_ff[1];
            d2_in = '0;
         end
         if (d3_in >= 2'd3) begin
            blink_in[2] = ~blink_ff[2];
            d3_in = '0;
         end
         if (d5_in >= 3'd5) begin
            blink_in[3] = ~blink_ff[3];
            d5_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_pend_ff <= 1'b0;
         ptr_ff     <= '0;
         limit_ff   <= PRESCALE_RESET;
         pc_ff      <= '0;
         d2_ff      <= '0;
         d3_ff      <= '0;
         d5_ff      <= '0;
         blink_ff   <= '0;
      end else begin
         rd_pend_ff <= rd_issue;
         ptr_ff     <= ptr_in;
         pc_ff      <= pc_in;
         d2_ff      <= d2_in;
         d3_ff      <= d3_in;
         d5_ff      <= d5_in;
         blink_ff   <= blink_in;
         if (csr_write_en) begin
            limit_ff <= csr_write_data;
         end
         if (wr_en) begin
            vld_ff[rd_addr_ff] <= 1'b1;
         end
      end
   end

   // timer memory: one read and one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         timer_mem[rd_addr_ff] <= wr_data;
      end
      if (rd_issue) begin
         rd_data_ff <= timer_mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      fired_ff <= fired_in;
      if (cmd.accept) begin
         op_ff      <= req_mode;
         idx_ff     <= req_timer_index;
         set_ff     <= req_set_count;
         kind_ff    <= req_timer_kind;
         en_ff      <= req_enable_in;
         stepped_ff <= step_go;
         cnt_ff     <= '0;
         enr_ff     <= 1'b0;
         trg_ff     <= 1'b0;
         knd_ff     <= '0;
      end else if (rd_pend_ff && (op_ff == MODE_READ) && idx_ok) begin
         cnt_ff <= cur.count;
         enr_ff <= cur.run;
         trg_ff <= cur.trig;
         knd_ff <= cur.kind;
      end
   end

   assign rsp_stepped       = stepped_ff;
   assign rsp_blink_1       = blink_ff[0];
   assign rsp_blink_2       = blink_ff[1];
   assign rsp_blink_3       = blink_ff[2];
   assign rsp_blink_5       = blink_ff[3];
   assign rsp_fired_mask    = fired_ff;
   assign rsp_count_value   = cnt_ff;
   assign rsp_enabled_out   = enr_ff;
   assign rsp_triggered_out = trg_ff;
   assign rsp_kind_out      = knd_ff;

endmodule

// ===== tb/sv/stb_checker.sv =====
// Checker for the software timer bank: predicts each result beat and compares it.
`timescale 1ns / 100ps
module stb_checker import stb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [INDEX_W-1:0] req_timer_index,
   input  logic [COUNT_W-1:0] req_set_count,
   input  logic [1:0]         req_timer_kind,
   input  logic               req_enable_in,
   input  logic               csr_write_en,
   input  logic [7:0]         csr_write_data,
   input  logic               rsp_valid,
   input  logic               rsp_stepped,
   input  logic               rsp_blink_1,
   input  logic               rsp_blink_2,
   input  logic               rsp_blink_3,
   input  logic               rsp_blink_5,
   input  logic [MASK_W-1:0]  rsp_fired_mask,
   input  logic [COUNT_W-1:0] rsp_count_value,
   input  logic               rsp_enabled_out,
   input  logic               rsp_triggered_out,
   input  logic [1:0]         rsp_kind_out,
   output int                 outstanding,
   output int                 mismatches,
   output int                 steps_seen,
   output int                 fires_seen
);

   typedef struct packed {
      logic               stepped;
      logic [3:0]         blink;   // bit 0 blink_1, 1 blink_2, 2 blink_3, 3 blink_5
      logic [MASK_W-1:0]  fired;
      logic [COUNT_W-1:0] count;
      logic               run;
      logic               trig;
      logic [1:0]         kind;
   } timer_beat_type;

   // Own copy of the timer bank and its prescaler.
   logic               tmr_run    [TIMER_COUNT];
   logic [COUNT_W-1:0] tmr_count  [TIMER_COUNT];
   logic [COUNT_W-1:0] tmr_target [TIMER_COUNT];
   logic [1:0]         tmr_kind   [TIMER_COUNT];
   logic               tmr_trig   [TIMER_COUNT];
   logic [7:0]         tick_count;
   logic [7:0]         step_limit;
   logic [1:0]         div2;
   logic [1:0]         div3;
   logic [2:0]         div5;
   logic [3:0]         blink;

   timer_beat_type awaited_beats[$];
   int             fail_total;
   int             step_total;
   int             fire_total;

   function automatic logic [MASK_W-1:0] run_timer_step();
      logic [MASK_W-1:0] fired;
      fired = '0;
      for (int i = 0; i < TIMER_COUNT; i++) begin
         if (tmr_run[i]) begin
            if (tmr_count[i] < tmr_target[i])
               tmr_count[i] = tmr_count[i] + 1'b1;
            if (tmr_count[i] >= tmr_target[i]) begin
               // one-shot and periodic clear; hold and kind three keep their count
               if (!tmr_kind[i][1]) begin
                  tmr_count[i] = '0;
                  tmr_run[i]   = (tmr_kind[i] == KIND_PERIODIC);
               end else begin
                  tmr_run[i] = 1'b0;
               end
               tmr_trig[i] = 1'b1;
               if (i < MASK_W)
                  fired[i] = 1'b1;
            end
         end else if (tmr_kind[i] != KIND_HOLD) begin
            tmr_count[i] = '0;
         end
      end
      return fired;
   endfunction

   function automatic void advance_blinks();
      blink[0] = ~blink[0];
      div2 = div2 + 1'b1;
      div3 = div3 + 1'b1;
      div5 = div5 + 1'b1;
      if (div2 >= 2'd2) begin blink[1] = ~blink[1]; div2 = '0; end
      if (div3 >= 2'd3) begin blink[2] = ~blink[2]; div3 = '0; end
      if (div5 >= 3'd5) begin blink[3] = ~blink[3]; div5 = '0; end
   endfunction

   function automatic timer_beat_type predict_timer_beat(
         input logic [1:0] mode, input logic [INDEX_W-1:0] idx,
         input logic [COUNT_W-1:0] set_count, input logic [1:0] kind, input logic en);
      timer_beat_type b;
      b = '0;
      case (mode)
         MODE_TICK: begin
            tick_count = tick_count + 8'd1;
            if (tick_count >= step_limit) begin
               tick_count = '0;
               b.fired    = run_timer_step();
               advance_blinks();
               b.stepped  = 1'b1;
            end
         end
         MODE_WRITE: begin
            tmr_target[idx] = set_count;
            tmr_kind[idx]   = kind;
            tmr_run[idx]    = en;
         end
         MODE_READ: begin
            b.count = tmr_count[idx];
            b.run   = tmr_run[idx];
            b.trig  = tmr_trig[idx];
            b.kind  = tmr_kind[idx];
         end
         MODE_CLEAR: tmr_trig[idx] = 1'b0;
         default: ;
      endcase
      b.blink = blink;
      return b;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_total++;
      end
   endtask

   always @(posedge clock) begin
      timer_beat_type got;
      timer_beat_type want;
      if (reset) begin
         for (int i = 0; i < TIMER_COUNT; i++) begin
            tmr_run[i]    = 1'b0;
            tmr_count[i]  = '0;
            tmr_target[i] = '0;
            tmr_kind[i]   = '0;
            tmr_trig[i]   = 1'b0;
         end
         tick_count = '0;
         step_limit = PRESCALE_RESET;
         div2       = '0;
         div3       = '0;
         div5       = '0;
         blink      = '0;
         awaited_beats.delete();
      end else begin
         if (csr_write_en)
            step_limit = csr_write_data;
         if (rsp_valid) begin
            got = '{rsp_stepped,
                    {rsp_blink_5, rsp_blink_3, rsp_blink_2, rsp_blink_1},
                    rsp_fired_mask, rsp_count_value, rsp_enabled_out,
                    rsp_triggered_out, rsp_kind_out};
            if (awaited_beats.size() == 0) begin
               $display("%0t: result beat with none expected, expected none, actual %0h",
                        $time, got);
               fail_total++;
            end else begin
               want = awaited_beats.pop_front();
               check_field("stepped", 32'(want.stepped), 32'(got.stepped));
               check_field("blink_1", 32'(want.blink[0]), 32'(got.blink[0]));
               check_field("blink_2", 32'(want.blink[1]), 32'(got.blink[1]));
               check_field("blink_3", 32'(want.blink[2]), 32'(got.blink[2]));
               check_field("blink_5", 32'(want.blink[3]), 32'(got.blink[3]));
               check_field("fired_mask", 32'(want.fired), 32'(got.fired));
               check_field("count_value", 32'(want.count), 32'(got.count));
               check_field("enabled_out", 32'(want.run), 32'(got.run));
               check_field("triggered_out", 32'(want.trig), 32'(got.trig));
               check_field("kind_out", 32'(want.kind), 32'(got.kind));
            end
         end
         if (start && !busy) begin
            want = predict_timer_beat(req_mode, req_timer_index, req_set_count,
                                      req_timer_kind, req_enable_in);
            if (want.stepped)
               step_total++;
            fire_total += $countones(want.fired);
            awaited_beats.push_back(want);
         end
      end
      outstanding <= awaited_beats.size();
      mismatches  <= fail_total;
      steps_seen  <= step_total;
      fires_seen  <= fire_total;
   end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the software timer bank testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
   import stb_pkg::*;

   // Kinds that the package leaves unnamed.
   localparam logic [1:0] KIND_ONE_SHOT   = 2'd0;
   localparam logic [1:0] KIND_STOP_CLEAR = 2'd3;   // stops like hold, clears when disabled

   localparam int PHASE_ITEMS    = 480;
   localparam int SETTLE_CYCLES  = TIMER_COUNT + 3;  // above the longest latency, a stepping tick
   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_mode = MODE_TICK;
   logic [INDEX_W-1:0] req_timer_index = '0;
   logic [COUNT_W-1:0] req_set_count = '0;
   logic [1:0]         req_timer_kind = KIND_ONE_SHOT;
   logic               req_enable_in = 1'b0;
   logic               csr_write_en = 1'b0;
   logic [7:0]         csr_write_data = '0;
   logic               rsp_valid;
   logic               rsp_stepped;
   logic               rsp_blink_1;
   logic               rsp_blink_2;
   logic               rsp_blink_3;
   logic               rsp_blink_5;
   logic [MASK_W-1:0]  rsp_fired_mask;
   logic [COUNT_W-1:0] rsp_count_value;
   logic               rsp_enabled_out;
   logic               rsp_triggered_out;
   logic [1:0]         rsp_kind_out;

   int outstanding;
   int mismatches;
   int steps_seen;
   int fires_seen;
   int idle_pct;
   int idle_cycles;
   int mode_count [4];
   int limit_writes;

   // 8 ns period: four high, four low.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   software_timer_bank u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_timer_index   (req_timer_index),
      .req_set_count     (req_set_count),
      .req_timer_kind    (req_timer_kind),
      .req_enable_in     (req_enable_in),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stepped       (rsp_stepped),
      .rsp_blink_1       (rsp_blink_1),
      .rsp_blink_2       (rsp_blink_2),
      .rsp_blink_3       (rsp_blink_3),
      .rsp_blink_5       (rsp_blink_5),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_count_value   (rsp_count_value),
      .rsp_enabled_out   (rsp_enabled_out),
      .rsp_triggered_out (rsp_triggered_out),
      .rsp_kind_out      (rsp_kind_out)
   );

   stb_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_timer_index   (req_timer_index),
      .req_set_count     (req_set_count),
      .req_timer_kind    (req_timer_kind),
      .req_enable_in     (req_enable_in),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_stepped       (rsp_stepped),
      .rsp_blink_1       (rsp_blink_1),
      .rsp_blink_2       (rsp_blink_2),
      .rsp_blink_3       (rsp_blink_3),
      .rsp_blink_5       (rsp_blink_5),
      .rsp_fired_mask    (rsp_fired_mask),
      .rsp_count_value   (rsp_count_value),
      .rsp_enabled_out   (rsp_enabled_out),
      .rsp_triggered_out (rsp_triggered_out),
      .rsp_kind_out      (rsp_kind_out),
      .outstanding       (outstanding),
      .mismatches        (mismatches),
      .steps_seen        (steps_seen),
      .fires_seen        (fires_seen)
   );

   // Watchdog: count cycles in which no item, result beat or register write
   // is taken; a stuck handshake ends the run here.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_en)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: watchdog expired with %0d beats outstanding", $time, outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Present one item from the falling edge and hold it until the block takes
   // it. Start stays high afterwards; the next item or a pause decides its
   // level at the following falling edge, so it is assigned once per step.
   task automatic send_item(input logic [1:0] mode, input logic [INDEX_W-1:0] idx,
                            input logic [COUNT_W-1:0] set_count, input logic [1:0] kind,
                            input logic en);
      @(negedge clock);
      start           <= 1'b1;
      req_mode        <= mode;
      req_timer_index <= idx;
      req_set_count   <= set_count;
      req_timer_kind  <= kind;
      req_enable_in   <= en;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      mode_count[mode]++;
   endtask

   // Drop start for a short random gap, so gaps land on every phase of the work.
   task automatic maybe_pause();
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(3);
         @(negedge clock);
         start <= 1'b0;
         repeat (gap)
            @(negedge clock);
      end
   endtask

   // Write the prescale limit only once the block has drained every beat.
   task automatic write_prescale(input logic [7:0] limit);
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (2)
         @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= limit;
      @(negedge clock);
      csr_write_en   <= 1'b0;
      limit_writes++;
   endtask

   // Favour small limits so that steps are frequent; the extremes still turn up.
   function automatic logic [7:0] pick_limit();
      case ($urandom_range(9))
         0:       return 8'd0;
         1:       return 8'd255;
         2:       return 8'($urandom);
         3:       return 8'd1;
         default: return 8'($urandom_range(2, 5));
      endcase
   endfunction

   // Mostly raw ticks and setup writes with small targets, so timers fire
   // often; the rest are reads, trigger clears and full-range targets.
   task automatic send_random_op();
      logic [1:0]         mode;
      logic [COUNT_W-1:0] set_count;
      int                 pick;
      pick = $urandom_range(99);
      if (pick < 55)
         mode = MODE_TICK;
      else if (pick < 75)
         mode = MODE_WRITE;
      else if (pick < 88)
         mode = MODE_READ;
      else
         mode = MODE_CLEAR;
      pick = $urandom_range(99);
      if (pick < 70)
         set_count = COUNT_W'($urandom_range(12));
      else if (pick < 80)
         set_count = '1;
      else
         set_count = COUNT_W'($urandom);
      send_item(mode, INDEX_W'($urandom_range(TIMER_COUNT - 1)), set_count,
                2'($urandom_range(3)), $urandom_range(9) != 0);
   endtask

   // One idling phase: chunks of random items, each under a fresh prescale limit.
   task automatic run_phase(input int pct);
      int left;
      int chunk;
      idle_pct = pct;
      left     = PHASE_ITEMS;
      while (left > 0) begin
         chunk = $urandom_range(40, 100);
         if (chunk > left)
            chunk = left;
         write_prescale(pick_limit());
         repeat (chunk) begin
            maybe_pause();
            send_random_op();
         end
         left -= chunk;
      end
   endtask

   initial begin
      idle_pct     = 0;
      limit_writes = 0;
      foreach (mode_count[m])
         mode_count[m] = 0;

      // Hold reset, then release it at a falling edge.
      repeat (11)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Under the reset limit of fifty: an untouched timer reads
      // as zeros and a lone raw tick runs no step.
      send_item(MODE_READ, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_TICK, 4'd0, '0, KIND_ONE_SHOT, 1'b0);

      // Zero limit: every raw tick steps. Set up one timer of each kind,
      // including a zero target and the largest target.
      write_prescale(8'd0);
      send_item(MODE_WRITE, 4'd0, '0, KIND_ONE_SHOT, 1'b1);
      send_item(MODE_WRITE, 4'd15, '1, KIND_HOLD, 1'b1);
      send_item(MODE_WRITE, 4'd1, 16'd2, KIND_PERIODIC, 1'b1);
      send_item(MODE_WRITE, 4'd2, 16'd1, KIND_STOP_CLEAR, 1'b1);
      send_item(MODE_WRITE, 4'd3, 16'd3, KIND_HOLD, 1'b1);
      repeat (3)
         send_item(MODE_TICK, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd2, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd3, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_CLEAR, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      // Disable: kind three loses its count on the next step, hold keeps it.
      // A setup write leaves count and trigger flag alone.
      send_item(MODE_WRITE, 4'd2, 16'd1, KIND_STOP_CLEAR, 1'b0);
      send_item(MODE_WRITE, 4'd3, 16'd3, KIND_HOLD, 1'b0);
      send_item(MODE_READ, 4'd3, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_TICK, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd2, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd15, '0, KIND_ONE_SHOT, 1'b0);

      // Lowered limit: build up the prescaler under the top limit, then drop
      // the limit below it so the very next raw tick steps.
      write_prescale(8'd255);
      repeat (4)
         send_item(MODE_TICK, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      write_prescale(8'd2);
      send_item(MODE_TICK, 4'd0, '0, KIND_ONE_SHOT, 1'b0);
      send_item(MODE_READ, 4'd1, '0, KIND_ONE_SHOT, 1'b0);

      // Random part: light sender idling, heavy idling, then back to back.
      run_phase(8);
      run_phase(57);
      run_phase(0);

      // Drain: wait for the last beat, then a step's worth of cycles for strays.
      @(negedge clock);
      start <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES)
         @(negedge clock);

      $display("Run covered %0d raw ticks, %0d setup writes, %0d reads, %0d trigger clears",
               mode_count[MODE_TICK], mode_count[MODE_WRITE], mode_count[MODE_READ],
               mode_count[MODE_CLEAR]);
      $display("over %0d prescale limit writes, with %0d timer steps and %0d timer firings",
               limit_writes, steps_seen, fires_seen);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/stb_pkg.sv
sv/stb_ctrl.sv
sv/stb_datapath.sv
sv/software_timer_bank.sv
tb/sv/stb_checker.sv
tb/sv/testbench.sv
